### hdl/bpr_pkg.sv
// Package for the button press/release event block.
// Holds shared constants, register indexes, the controller state type and
// the control structs passed between the controller, lanes and merge stage.
package bpr_pkg;

  localparam int NUM_BUTTONS_DEF      = 3;
  localparam int SLOTS_PER_BUTTON_DEF = 4;
  localparam int TIME_BITS_DEF        = 32;

  localparam int TIME_W       = 32;
  localparam int PIN_W        = 3;
  localparam int IDX_W        = 2;
  localparam int FIRED_W      = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int INTERVAL_W   = 16;
  localparam int SLOT_W       = 16;
  localparam int DUR_W        = 14;
  localparam int SLOT_VALID   = 15;
  localparam int SLOT_RELEASE = 14;
  localparam int SLOT_REGS    = 3;
  localparam int MAX_EVENTS   = 3;
  localparam int EVT_CNT_W    = 3;

  localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON0_SLOTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON1_SLOTS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON2_SLOTS   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MATCH,
    ST_EMIT
  } bpr_state_e;

  typedef struct packed {
    logic sample;
    logic match;
  } bpr_lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic run;
  } bpr_merge_ctrl_t;

endpackage

### hdl/bpr_if.sv
// Valid/ready channel interfaces for ticks in and events out.
// Depends on bpr_pkg for field widths.
interface bpr_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpr_pkg::TIME_W-1:0] time_ms;
  logic [bpr_pkg::PIN_W-1:0]  pin_levels;

  modport source (output valid, output time_ms, output pin_levels, input ready);
  modport sink   (input valid, input time_ms, input pin_levels, output ready);
endinterface

interface bpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpr_pkg::IDX_W-1:0]   button_index;
  logic                        event_kind;
  logic [bpr_pkg::TIME_W-1:0]  held_time;
  logic [bpr_pkg::FIRED_W-1:0] fired_slots;
  logic                        last_event;

  modport source (output valid, output button_index, output event_kind,
                  output held_time, output fired_slots, output last_event,
                  input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input held_time, input fired_slots, input last_event,
                  output ready);
endinterface

### hdl/bpr_lane.sv
// One button lane: stored press state, press start time, event capture
// and handler slot matching. Depends on bpr_pkg.
module bpr_lane #(
  parameter int SLOTS_PER_BUTTON = bpr_pkg::SLOTS_PER_BUTTON_DEF,
  parameter int TIME_BITS        = bpr_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpr_pkg::bpr_lane_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0]              now_i,
  input  logic                              pressed_now_i,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]    slots_i,
  output logic                              ev_valid_o,
  output logic                              release_o,
  output logic [TIME_BITS-1:0]              held_o,
  output logic [SLOTS_PER_BUTTON-1:0]       mask_o
);

  logic                        pressed_q;
  logic [TIME_BITS-1:0]        start_q;
  logic                        ev_q;
  logic                        rel_q;
  logic [TIME_BITS-1:0]        held_q;
  logic [SLOTS_PER_BUTTON-1:0] mask_q;
  logic [SLOTS_PER_BUTTON-1:0] mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      start_q   <= '0;
      ev_q      <= 1'b0;
    end else if (ctrl_i.sample) begin
      ev_q <= (pressed_now_i != pressed_q);
      if (pressed_now_i != pressed_q) begin
        pressed_q <= pressed_now_i;
        if (!pressed_q) begin
          start_q <= now_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample) begin
      rel_q  <= pressed_q;
      held_q <= pressed_q ? (now_i - start_q) : '0;
    end
    if (ctrl_i.match) begin
      mask_q <= mask_d;
    end
  end

  always_comb begin
    logic                        alive;
    logic [bpr_pkg::SLOT_W-1:0]  s;
    logic [TIME_BITS-1:0]        dur;
    alive  = 1'b1;
    mask_d = '0;
    for (int k = 0; k < SLOTS_PER_BUTTON; k++) begin
      s   = slots_i[k*bpr_pkg::SLOT_W +: bpr_pkg::SLOT_W];
      dur = {{(TIME_BITS-bpr_pkg::DUR_W){1'b0}}, s[bpr_pkg::DUR_W-1:0]};
      if (!s[bpr_pkg::SLOT_VALID]) begin
        alive = 1'b0;
      end
      if (alive && (s[bpr_pkg::SLOT_RELEASE] == rel_q) &&
          (!rel_q || (dur == '0) || (dur < held_q))) begin
        mask_d[k] = 1'b1;
      end
    end
  end

  assign ev_valid_o = ev_q;
  assign release_o  = rel_q;
  assign held_o     = held_q;
  assign mask_o     = mask_q;

endmodule

### hdl/bpr_merge.sv
// Merge stage: picks lane events in button order, caps them per tick,
// and drives the registered event output. Depends on bpr_pkg, bpr_if.
module bpr_merge #(
  parameter int NUM_BUTTONS      = bpr_pkg::NUM_BUTTONS_DEF,
  parameter int SLOTS_PER_BUTTON = bpr_pkg::SLOTS_PER_BUTTON_DEF,
  parameter int TIME_BITS        = bpr_pkg::TIME_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bpr_pkg::bpr_merge_ctrl_t                      ctrl_i,
  input  logic [NUM_BUTTONS-1:0]                        ev_valid_i,
  input  logic [NUM_BUTTONS-1:0]                        release_i,
  input  logic [NUM_BUTTONS-1:0][TIME_BITS-1:0]         held_i,
  input  logic [NUM_BUTTONS-1:0][SLOTS_PER_BUTTON-1:0]  mask_i,
  output logic                                          busy_o,
  bpr_out_if.source                                     out_o
);

  logic [NUM_BUTTONS-1:0]      pend_q, pend_d, sel;
  logic                        vld_q;
  logic                        take;
  logic [bpr_pkg::IDX_W-1:0]   idx_d, idx_q;
  logic                        kind_d, kind_q;
  logic [TIME_BITS-1:0]        held_d;
  logic [bpr_pkg::TIME_W-1:0]  held_q;
  logic [SLOTS_PER_BUTTON-1:0] mask_d;
  logic [bpr_pkg::FIRED_W-1:0] mask_q;
  logic                        last_q;

  always_comb begin
    logic found;
    found  = 1'b0;
    sel    = '0;
    idx_d  = '0;
    kind_d = 1'b0;
    held_d = '0;
    mask_d = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pend_q[i] && !found) begin
        found  = 1'b1;
        sel[i] = 1'b1;
        idx_d  = bpr_pkg::IDX_W'(i);
        kind_d = release_i[i];
        held_d = held_i[i];
        mask_d = mask_i[i];
      end
    end
  end

  assign take = ctrl_i.run && (pend_q != '0) && (!vld_q || out_o.ready);

  always_comb begin
    logic [bpr_pkg::EVT_CNT_W-1:0] cnt;
    cnt    = '0;
    pend_d = pend_q;
    if (ctrl_i.load) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        pend_d[i] = ev_valid_i[i] && (cnt < bpr_pkg::EVT_CNT_W'(bpr_pkg::MAX_EVENTS));
        if (ev_valid_i[i]) begin
          cnt = cnt + 1'b1;
        end
      end
    end else if (take) begin
      pend_d = pend_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (take) begin
        vld_q <= 1'b1;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q  <= idx_d;
      kind_q <= kind_d;
      held_q <= bpr_pkg::TIME_W'(held_d);
      mask_q <= bpr_pkg::FIRED_W'(mask_d);
      last_q <= ((pend_q & ~sel) == '0);
    end
  end

  assign busy_o             = (pend_q != '0);
  assign out_o.valid        = vld_q;
  assign out_o.button_index = idx_q;
  assign out_o.event_kind   = kind_q;
  assign out_o.held_time    = held_q;
  assign out_o.fired_slots  = mask_q;
  assign out_o.last_event   = last_q;

endmodule

### hdl/button_press_release_events.sv
// Button press/release event block: top level with controller, config
// registers, one lane per button and the merge stage.
// Each accepted tick goes to the check state; a sampled tick goes on through
// the match and emit states, which send up to 3 events in button order, and
// a tick that does not sample returns to idle. Output stalls hold the emit state.
// The output register lets the next tick be taken while an event waits.
// Reset (async, active low): all buttons released, start and last sample times zero, interval 200.
module button_press_release_events #(
  parameter int NUM_BUTTONS      = bpr_pkg::NUM_BUTTONS_DEF,
  parameter int SLOTS_PER_BUTTON = bpr_pkg::SLOTS_PER_BUTTON_DEF,
  parameter int TIME_BITS        = bpr_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bpr_in_if.sink                           in_i,
  bpr_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  bpr_pkg::bpr_state_e state_q, state_d;

  logic [bpr_pkg::INTERVAL_W-1:0] interval_q;
  logic [bpr_pkg::CFG_DATA_W-1:0] slots_q [bpr_pkg::SLOT_REGS];
  logic [TIME_BITS-1:0]           last_q;
  logic [TIME_BITS-1:0]           now_q;
  logic [bpr_pkg::PIN_W-1:0]      lvl_q;
  logic                           in_xfer;
  logic                           due;
  logic                           busy;

  bpr_pkg::bpr_lane_ctrl_t  lane_ctrl;
  bpr_pkg::bpr_merge_ctrl_t merge_ctrl;

  logic [NUM_BUTTONS-1:0]                       ev_valid, release_w;
  logic [NUM_BUTTONS-1:0][TIME_BITS-1:0]        held;
  logic [NUM_BUTTONS-1:0][SLOTS_PER_BUTTON-1:0] mask;

  assign in_i.ready = (state_q == bpr_pkg::ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign due        = ((now_q - last_q) >=
                       {{(TIME_BITS-bpr_pkg::INTERVAL_W){1'b0}}, interval_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= bpr_pkg::SAMPLE_INTERVAL_RST;
      for (int b = 0; b < bpr_pkg::SLOT_REGS; b++) begin
        slots_q[b] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpr_pkg::CFG_SAMPLE_INTERVAL: interval_q <= cfg_data_i[bpr_pkg::INTERVAL_W-1:0];
        bpr_pkg::CFG_BUTTON0_SLOTS:   slots_q[0] <= cfg_data_i;
        bpr_pkg::CFG_BUTTON1_SLOTS:   slots_q[1] <= cfg_data_i;
        bpr_pkg::CFG_BUTTON2_SLOTS:   slots_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpr_pkg::ST_IDLE;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      if (lane_ctrl.sample) begin
        last_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q <= in_i.time_ms[TIME_BITS-1:0];
      lvl_q <= in_i.pin_levels;
    end
  end

  always_comb begin
    state_d          = state_q;
    lane_ctrl        = '0;
    merge_ctrl       = '0;
    unique case (state_q)
      bpr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = bpr_pkg::ST_CHECK;
        end
      end
      bpr_pkg::ST_CHECK: begin
        if (due) begin
          lane_ctrl.sample = 1'b1;
          state_d          = bpr_pkg::ST_MATCH;
        end else begin
          state_d = bpr_pkg::ST_IDLE;
        end
      end
      bpr_pkg::ST_MATCH: begin
        lane_ctrl.match = 1'b1;
        merge_ctrl.load = 1'b1;
        state_d         = bpr_pkg::ST_EMIT;
      end
      bpr_pkg::ST_EMIT: begin
        merge_ctrl.run = 1'b1;
        if (!busy) begin
          state_d = bpr_pkg::ST_IDLE;
        end
      end
      default: state_d = bpr_pkg::ST_IDLE;
    endcase
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic                           pressed_now;
    logic [bpr_pkg::CFG_DATA_W-1:0] lane_slots;

    if (b < bpr_pkg::SLOT_REGS) begin : g_pin
      assign pressed_now = !lvl_q[b];
      assign lane_slots  = slots_q[b];
    end else begin : g_nopin
      assign pressed_now = 1'b1;
      assign lane_slots  = '0;
    end

    bpr_lane #(
      .SLOTS_PER_BUTTON (SLOTS_PER_BUTTON),
      .TIME_BITS        (TIME_BITS)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (lane_ctrl),
      .now_i         (now_q),
      .pressed_now_i (pressed_now),
      .slots_i       (lane_slots),
      .ev_valid_o    (ev_valid[b]),
      .release_o     (release_w[b]),
      .held_o        (held[b]),
      .mask_o        (mask[b])
    );
  end

  bpr_merge #(
    .NUM_BUTTONS      (NUM_BUTTONS),
    .SLOTS_PER_BUTTON (SLOTS_PER_BUTTON),
    .TIME_BITS        (TIME_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (merge_ctrl),
    .ev_valid_i (ev_valid),
    .release_i  (release_w),
    .held_i     (held),
    .mask_i     (mask),
    .busy_o     (busy),
    .out_o      (out_o)
  );

endmodule
